>>> rtl/fla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fla_pkg;

   localparam int MaxSymbolSamples = 65536;

   localparam int CountW  = $clog2(2 * MaxSymbolSamples);
   localparam int IndexW  = $clog2(8 * MaxSymbolSamples);
   localparam int SampleW = 32;
   localparam int PeakW   = 31;
   localparam int SymW    = 2;
   localparam int AddrW   = 4;
   localparam int DataW   = 32;

   localparam logic [CountW-1:0] CountMax = CountW'(2 * MaxSymbolSamples - 1);
   localparam logic [IndexW-1:0] IndexMax = IndexW'(8 * MaxSymbolSamples - 1);

   typedef struct packed {
      logic [PeakW-1:0] band1_low;
      logic [PeakW-1:0] band1_high;
      logic [PeakW-1:0] band2_low;
      logic [PeakW-1:0] band2_high;
   } bands_type;

   typedef struct packed {
      logic             valid;
      logic [PeakW-1:0] peak;
   } win_type;

endpackage
`default_nettype wire

>>> rtl/fla_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fla_req_if;
   import fla_pkg::*;
   logic               valid;
   logic               ready;
   logic               restart;
   logic [SampleW-1:0] sample;
   modport source (output valid, output restart, output sample, input ready);
   modport sink (input valid, input restart, input sample, output ready);
endinterface

interface fla_rsp_if;
   import fla_pkg::*;
   logic             valid;
   logic             ready;
   logic [SymW-1:0]  symbol;
   logic [PeakW-1:0] peak;
   modport source (output valid, output symbol, output peak, input ready);
   modport sink (input valid, input symbol, input peak, output ready);
endinterface
`default_nettype wire

>>> rtl/four_level_ask_demodulator.sv
// four-level ask demodulator with peak detection
// req_ch carries one item per sample: restart flag and a signed 32-bit sample.
// rsp_ch carries one item per finished symbol window: symbol and window peak.
// the csr port (apb style, always ready) holds the two inclusive peak bands;
// write it only while no item is in flight.
// the front takes one sample per cycle unless the queue is full, measures the
// preamble, skips the first four symbol lengths and tracks the window peak; a
// finished window goes into a two-entry queue, and the back decodes it into a
// registered result.
// throughput: one sample per cycle, as the front updates its state for each sample;
// req ready drops only while the queue is full.
// reset clears all tracking state and loads the default bands; restart on an
// item clears the tracking state only. when the receiver stalls, the result
// holds, the queue fills, and then the input is stalled.
`timescale 1ns / 1ps
`default_nettype none
module four_level_ask_demodulator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   fla_req_if.sink                        req_ch,
   fla_rsp_if.source                      rsp_ch,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [fla_pkg::AddrW-1:0] paddr,
   input  wire logic [fla_pkg::DataW-1:0] pwdata,
   output      logic [fla_pkg::DataW-1:0] prdata,
   output      logic                      pready
);
   import fla_pkg::*;

   bands_type bands;
   win_type   push;
   win_type   head;
   logic      queue_full;
   logic      pop;

   fla_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .bands   (bands)
   );

   fla_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   fla_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   fla_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .bands (bands),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule
`default_nettype wire

>>> rtl/fla_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module fla_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [fla_pkg::AddrW-1:0] paddr,
   input  wire logic [fla_pkg::DataW-1:0] pwdata,
   output      logic [fla_pkg::DataW-1:0] prdata,
   output      logic                    pready,
   output      fla_pkg::bands_type      bands
);
   import fla_pkg::*;

   localparam logic [1:0] RegBand1Low  = 2'd0;
   localparam logic [1:0] RegBand1High = 2'd1;
   localparam logic [1:0] RegBand2Low  = 2'd2;
   localparam logic [1:0] RegBand2High = 2'd3;

   bands_type   bands_ff, bands_in;
   logic        wr_en;
   logic [1:0]  reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      bands_in = bands_ff;
      if (wr_en) begin
         case (reg_sel)
            RegBand1Low:  bands_in.band1_low  = pwdata[PeakW-1:0];
            RegBand1High: bands_in.band1_high = pwdata[PeakW-1:0];
            RegBand2Low:  bands_in.band2_low  = pwdata[PeakW-1:0];
            RegBand2High: bands_in.band2_high = pwdata[PeakW-1:0];
            default:      bands_in = bands_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         RegBand1Low:  prdata = {1'b0, bands_ff.band1_low};
         RegBand1High: prdata = {1'b0, bands_ff.band1_high};
         RegBand2Low:  prdata = {1'b0, bands_ff.band2_low};
         RegBand2High: prdata = {1'b0, bands_ff.band2_high};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bands_ff.band1_low  <= PeakW'(703133123);
         bands_ff.band1_high <= PeakW'(717337831);
         bands_ff.band2_low  <= PeakW'(1406266245);
         bands_ff.band2_high <= PeakW'(1434675663);
      end else begin
         bands_ff <= bands_in;
      end
   end

   assign bands = bands_ff;

endmodule
`default_nettype wire

>>> rtl/fla_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fla_front (
   input  wire logic clock,
   input  wire logic reset,
   fla_req_if.sink   req,
   input  wire logic queue_full,
   output fla_pkg::win_type push
);
   import fla_pkg::*;

   localparam logic [1:0] PhZeros  = 2'd0;
   localparam logic [1:0] PhBurst  = 2'd1;
   localparam logic [1:0] PhDecode = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [CountW-1:0] zero_run_ff, zero_run_in;
   logic [CountW-1:0] burst_ff, burst_in;
   logic              zero_pend_ff, zero_pend_in;
   logic [CountW-1:0] sym_len_ff, sym_len_in;
   logic [IndexW-1:0] index_ff, index_in;
   logic [CountW-1:0] win_cnt_ff, win_cnt_in;
   logic [PeakW-1:0]  win_peak_ff, win_peak_in;

   logic [1:0]        ph;
   logic [CountW-1:0] zr, bc, sl, wc, wc_next;
   logic              zp;
   logic [IndexW-1:0] idx, skip_pt;
   logic [PeakW-1:0]  wp, peak_next;
   logic [CountW:0]   burst_sum, len_sum;
   logic              accept, is_zero, done;

   assign req.ready = ~queue_full;
   assign accept    = req.valid & ~queue_full;
   assign is_zero   = (req.sample == '0);

   always_comb begin
      ph  = req.restart ? PhZeros : phase_ff;
      zr  = req.restart ? '0 : zero_run_ff;
      bc  = req.restart ? '0 : burst_ff;
      zp  = req.restart ? 1'b0 : zero_pend_ff;
      sl  = req.restart ? '0 : sym_len_ff;
      idx = req.restart ? '0 : index_ff;
      wc  = req.restart ? '0 : win_cnt_ff;
      wp  = req.restart ? '0 : win_peak_ff;

      burst_sum = {1'b0, bc} + (zp ? (CountW+1)'(2) : (CountW+1)'(1));
      len_sum   = {1'b0, zr} + {1'b0, bc};
      skip_pt   = IndexW'({sl, 2'b00});
      peak_next = (~req.sample[SampleW-1] && req.sample[PeakW-1:0] > wp)
                  ? req.sample[PeakW-1:0] : wp;
      wc_next   = wc + 1'b1;
      done      = 1'b0;

      phase_in     = ph;
      zero_run_in  = zr;
      burst_in     = bc;
      zero_pend_in = zp;
      sym_len_in   = sl;
      index_in     = (idx == IndexMax) ? idx : idx + 1'b1;
      win_cnt_in   = wc;
      win_peak_in  = wp;

      case (ph)
         PhZeros: begin
            if (is_zero) begin
               zero_run_in = (zr == CountMax) ? zr : zr + 1'b1;
            end else begin
               burst_in = (bc == CountMax) ? bc : bc + 1'b1;
               phase_in = PhBurst;
            end
         end
         PhBurst: begin
            if (is_zero) begin
               if (zp) begin
                  zero_pend_in = 1'b0;
                  sym_len_in   = len_sum[CountW:1];
                  win_cnt_in   = '0;
                  win_peak_in  = '0;
                  phase_in     = PhDecode;
               end else begin
                  zero_pend_in = 1'b1;
               end
            end else begin
               burst_in     = (burst_sum > {1'b0, CountMax}) ? CountMax
                                                             : burst_sum[CountW-1:0];
               zero_pend_in = 1'b0;
            end
         end
         PhDecode: begin
            if (sl != '0 && idx >= skip_pt) begin
               if (wc_next >= sl) begin
                  done        = 1'b1;
                  win_cnt_in  = '0;
                  win_peak_in = '0;
               end else begin
                  win_cnt_in  = wc_next;
                  win_peak_in = peak_next;
               end
            end
         end
         default: phase_in = ph;
      endcase
   end

   assign push.valid = accept & done;
   assign push.peak  = peak_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhZeros;
         zero_run_ff  <= '0;
         burst_ff     <= '0;
         zero_pend_ff <= 1'b0;
         sym_len_ff   <= '0;
         index_ff     <= '0;
         win_cnt_ff   <= '0;
         win_peak_ff  <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         zero_run_ff  <= zero_run_in;
         burst_ff     <= burst_in;
         zero_pend_ff <= zero_pend_in;
         sym_len_ff   <= sym_len_in;
         index_ff     <= index_in;
         win_cnt_ff   <= win_cnt_in;
         win_peak_ff  <= win_peak_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/fla_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module fla_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fla_pkg::win_type push,
   input  wire logic             pop,
   output fla_pkg::win_type      head,
   output      logic             full
);
   import fla_pkg::*;

   logic [PeakW-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.peak  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop & head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/fla_back.sv
`timescale 1ns / 1ps
`default_nettype none
module fla_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fla_pkg::win_type   head,
   input  wire fla_pkg::bands_type bands,
   output      logic               pop,
   fla_rsp_if.source               rsp
);
   import fla_pkg::*;

   localparam logic [SymW-1:0] SymNone  = 2'd0;
   localparam logic [SymW-1:0] SymBand1 = 2'd1;
   localparam logic [SymW-1:0] SymBand2 = 2'd2;
   localparam logic [SymW-1:0] SymOther = 2'd3;

   logic             valid_ff, valid_in;
   logic [SymW-1:0]  symbol_ff, symbol_in;
   logic [PeakW-1:0] peak_ff;

   assign pop = head.valid & (~valid_ff | rsp.ready);

   always_comb begin
      if (head.peak == '0) begin
         symbol_in = SymNone;
      end else if (head.peak >= bands.band1_low && head.peak <= bands.band1_high) begin
         symbol_in = SymBand1;
      end else if (head.peak >= bands.band2_low && head.peak <= bands.band2_high) begin
         symbol_in = SymBand2;
      end else begin
         symbol_in = SymOther;
      end
      valid_in = pop | (valid_ff & ~rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         symbol_ff <= symbol_in;
         peak_ff   <= head.peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid  = valid_ff;
   assign rsp.symbol = symbol_ff;
   assign rsp.peak   = peak_ff;

endmodule
`default_nettype wire

>>> dv/fla_tb_pkg.sv
`timescale 1ns / 1ps
package fla_tb_pkg;
   import fla_pkg::*;

   typedef enum logic [AddrW-1:0] {
      Band1LowAddr  = 4'h0,
      Band1HighAddr = 4'h4,
      Band2LowAddr  = 4'h8,
      Band2HighAddr = 4'hC
   } csr_addr_type;

   localparam logic [PeakW-1:0] Band1LowReset  = 31'd703133123;
   localparam logic [PeakW-1:0] Band1HighReset = 31'd717337831;
   localparam logic [PeakW-1:0] Band2LowReset  = 31'd1406266245;
   localparam logic [PeakW-1:0] Band2HighReset = 31'd1434675663;

   typedef struct packed {
      logic [SymW-1:0]  symbol;
      logic [PeakW-1:0] peak;
   } symbol_item_type;

endpackage

>>> dv/four_level_ask_demodulator_checker.sv
`timescale 1ns / 1ps
module four_level_ask_demodulator_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   fla_req_if                             req_mon,
   fla_rsp_if                             rsp_mon,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic                      pready,
   input  wire logic [fla_pkg::AddrW-1:0] paddr,
   input  wire logic [fla_pkg::DataW-1:0] pwdata,
   output int                             failures,
   output int                             pending
);
   import fla_pkg::*;
   import fla_tb_pkg::*;

   typedef enum logic [1:0] {MeasZeros, MeasBurst, Decoding} demod_phase_type;

   localparam logic [SymW-1:0] Sym00 = 2'd0;
   localparam logic [SymW-1:0] Sym01 = 2'd1;
   localparam logic [SymW-1:0] Sym10 = 2'd2;
   localparam logic [SymW-1:0] Sym11 = 2'd3;

   logic [PeakW-1:0]  band1_lo, band1_hi, band2_lo, band2_hi;
   demod_phase_type   phase;
   logic [CountW-1:0] zero_run, burst_len, sym_len, win_count;
   logic              zero_seen;
   logic [IndexW-1:0] sample_idx;
   logic [PeakW-1:0]  win_peak;
   symbol_item_type   expected_symbols[$];

   function automatic logic [CountW-1:0] count_add(input logic [CountW-1:0] a,
                                                   input logic [1:0] inc);
      logic [CountW:0] s;
      s = a + inc;
      return (s > CountMax) ? CountMax : s[CountW-1:0];
   endfunction

   task automatic clear_tracking();
      phase      = MeasZeros;
      zero_run   = '0;
      burst_len  = '0;
      zero_seen  = 1'b0;
      sym_len    = '0;
      sample_idx = '0;
      win_count  = '0;
      win_peak   = '0;
   endtask

   task automatic demod_sample(input logic restart, input logic [SampleW-1:0] smp);
      logic [IndexW-1:0] idx;
      logic [CountW:0]   total;
      symbol_item_type   res;
      if (restart) clear_tracking();
      idx = sample_idx;
      if (sample_idx != IndexMax) sample_idx = sample_idx + 1'b1;
      case (phase)
         MeasZeros: begin
            if (smp == '0) begin
               zero_run = count_add(zero_run, 2'd1);
            end else begin
               burst_len = count_add(burst_len, 2'd1);
               phase     = MeasBurst;
            end
         end
         MeasBurst: begin
            if (smp == '0) begin
               if (zero_seen) begin
                  zero_seen = 1'b0;
                  total     = zero_run + burst_len;
                  sym_len   = total[CountW:1];
                  win_count = '0;
                  win_peak  = '0;
                  phase     = Decoding;
               end else begin
                  zero_seen = 1'b1;
               end
            end else begin
               burst_len = count_add(burst_len, zero_seen ? 2'd2 : 2'd1);
               zero_seen = 1'b0;
            end
         end
         Decoding: begin
            if (sym_len != '0 && idx >= {sym_len, 2'b00}) begin
               if (!smp[SampleW-1] && smp[PeakW-1:0] > win_peak) win_peak = smp[PeakW-1:0];
               win_count = win_count + 1'b1;
               if (win_count >= sym_len) begin
                  res.peak = win_peak;
                  if (win_peak == '0) res.symbol = Sym00;
                  else if (win_peak >= band1_lo && win_peak <= band1_hi) res.symbol = Sym01;
                  else if (win_peak >= band2_lo && win_peak <= band2_hi) res.symbol = Sym10;
                  else res.symbol = Sym11;
                  expected_symbols = {expected_symbols, res};
                  win_count = '0;
                  win_peak  = '0;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      symbol_item_type got, want;
      if (reset) begin
         band1_lo = Band1LowReset;
         band1_hi = Band1HighReset;
         band2_lo = Band2LowReset;
         band2_hi = Band2HighReset;
         clear_tracking();
         expected_symbols.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               Band1LowAddr:  band1_lo = pwdata[PeakW-1:0];
               Band1HighAddr: band1_hi = pwdata[PeakW-1:0];
               Band2LowAddr:  band2_lo = pwdata[PeakW-1:0];
               Band2HighAddr: band2_hi = pwdata[PeakW-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) demod_sample(req_mon.restart, req_mon.sample);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.symbol = rsp_mon.symbol;
            got.peak   = rsp_mon.peak;
            if (expected_symbols.size() == 0) begin
               $error("unexpected item: symbol %0d peak %0d", got.symbol, got.peak);
               failures++;
            end else begin
               want = expected_symbols.pop_front();
               if (got.symbol !== want.symbol) begin
                  $error("symbol: expected %0d, actual %0d", want.symbol, got.symbol);
                  failures++;
               end
               if (got.peak !== want.peak) begin
                  $error("peak: expected %0d, actual %0d", want.peak, got.peak);
                  failures++;
               end
            end
         end
      end
      pending = expected_symbols.size();
   end

endmodule

>>> dv/four_level_ask_demodulator_tb.sv
`timescale 1ns / 1ps
module four_level_ask_demodulator_tb;
   import fla_pkg::*;
   import fla_tb_pkg::*;

   localparam int DrainCycles = 8;
   localparam int RandomItems = 1900;
   localparam int Phases      = 6;

   typedef enum int {RxOpen, RxCoin, RxMostly, RxChoked} rx_mode_type;

   logic             clock, reset;
   logic             psel, penable, pwrite, pready;
   logic [AddrW-1:0] paddr;
   logic [DataW-1:0] pwdata, prdata;
   int               failures, pending;

   logic [PeakW-1:0] b1_lo, b1_hi, b2_lo, b2_hi;
   int               burst_left, samples_sent;
   logic             gaps_on;

   fla_req_if req_ch();
   fla_rsp_if rsp_ch();

   four_level_ask_demodulator dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   four_level_ask_demodulator_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_ch),
      .rsp_mon  (rsp_ch),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .pready   (pready),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("four_level_ask_demodulator: mismatch");
      $finish;
   end

   // result side stalls on its own schedule
   initial begin
      rx_mode_type mode;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         repeat ($urandom_range(50, 300)) begin
            @(posedge clock);
            case (mode)
               RxOpen:   rsp_ch.ready <= 1'b1;
               RxCoin:   rsp_ch.ready <= 1'($urandom);
               RxMostly: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
               default:  rsp_ch.ready <= ($urandom_range(0, 19) == 0);
            endcase
         end
      end
   end

   task automatic send(input logic restart, input logic [SampleW-1:0] smp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.restart <= restart;
      req_ch.sample  <= smp;
      do @(posedge clock); while (!req_ch.ready);
      samples_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input csr_addr_type addr, input logic [PeakW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {1'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (addr)
         Band1LowAddr:  b1_lo = value;
         Band1HighAddr: b1_hi = value;
         Band2LowAddr:  b2_lo = value;
         default:       b2_hi = value;
      endcase
   endtask

   task automatic set_bands(input logic [PeakW-1:0] l1, input logic [PeakW-1:0] h1,
                            input logic [PeakW-1:0] l2, input logic [PeakW-1:0] h2);
      csr_write(Band1LowAddr, l1);
      csr_write(Band1HighAddr, h1);
      csr_write(Band2LowAddr, l2);
      csr_write(Band2HighAddr, h2);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [SampleW-1:0] nonzero_sample();
      logic [SampleW-1:0] v;
      do v = $urandom; while (v == '0);
      return v;
   endfunction

   function automatic logic [PeakW-1:0] pick_peak();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return b1_lo;
         2: return b1_hi;
         3: return b2_lo;
         4: return b2_hi;
         5: return b1_lo - 1'b1;
         6: return b2_hi + 1'b1;
         7: return PeakW'($urandom_range(b1_hi, b1_lo));
         8: return PeakW'($urandom_range(b2_hi, b2_lo));
         default: return PeakW'($urandom);
      endcase
   endfunction

   function automatic logic [SampleW-1:0] window_filler(input logic [PeakW-1:0] pk);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return {1'b1, PeakW'($urandom)};
         default: return {1'b0, PeakW'($urandom_range(pk))};
      endcase
   endfunction

   task automatic send_window(input int len);
      logic [PeakW-1:0] pk;
      int at;
      pk = pick_peak();
      at = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
         if (i == at) send(1'b0, {1'b0, pk});
         else send(1'b0, window_filler(pk));
      end
   endtask

   // preamble, skip, then whole windows and a ragged tail
   task automatic send_frame(input int len);
      int total, zeros, burst, done, idx, start;
      total = 2 * len + $urandom_range(0, 1);
      zeros = $urandom_range(0, total - 1);
      burst = total - zeros;
      idx = 0;
      for (int i = 0; i < zeros; i++) begin
         send(i == 0, '0);
         idx++;
      end
      send(zeros == 0, nonzero_sample());
      idx++;
      done = 1;
      while (done < burst) begin
         if (burst - done >= 2 && $urandom_range(0, 3) == 0) begin
            send(1'b0, '0);
            send(1'b0, nonzero_sample());
            idx += 2;
            done += 2;
         end else begin
            send(1'b0, nonzero_sample());
            idx++;
            done++;
         end
      end
      send(1'b0, '0);
      send(1'b0, '0);
      idx += 2;
      start = (4 * len > idx) ? 4 * len : idx;
      while (idx < start) begin
         send(1'b0, $urandom);
         idx++;
      end
      repeat ($urandom_range(1, 8)) send_window(len);
      repeat ($urandom_range(0, len)) send(1'b0, $urandom);
   endtask

   task automatic send_noise(input int n);
      repeat (n) send($urandom_range(0, 9) == 0, ($urandom_range(0, 2) == 0) ? '0 : $urandom);
   endtask

   initial begin
      int phase_end;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
      req_ch.sample  <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      b1_lo = Band1LowReset;
      b1_hi = Band1HighReset;
      b2_lo = Band2LowReset;
      b2_hi = Band2HighReset;
      burst_left   = 0;
      samples_sent = 0;
      gaps_on      = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // one-sample symbols: peak extremes and band edges
      send(1'b1, '0);
      send(1'b0, 32'h0000_0005);
      send(1'b0, '0);
      send(1'b0, '0);
      send(1'b0, 32'h7FFF_FFFF);
      send(1'b0, 32'h8000_0000);
      send(1'b0, {1'b0, b1_lo});
      send(1'b0, {1'b0, b1_hi});
      send(1'b0, {1'b0, b2_lo});
      send(1'b0, {1'b0, b2_hi});
      send(1'b0, {1'b0, b1_hi + 1'b1});
      send(1'b0, 32'hFFFF_FFFF);
      send(1'b0, 32'h0000_0001);
      // zero symbol length
      send(1'b1, 32'h0000_1234);
      send(1'b0, '0);
      send(1'b0, '0);
      send(1'b0, 32'h0000_7777);
      send(1'b0, 32'h0000_0001);
      // skip point already behind the end of the preamble
      send(1'b1, 32'h0000_AAAA);
      send(1'b0, '0);
      send(1'b0, 32'h0000_0055);
      send(1'b0, '0);
      send(1'b0, '0);
      send(1'b0, 32'h0000_0100);
      send(1'b0, 32'hF000_0000);

      for (int p = 0; p < Phases; p++) begin
         drain();
         case (p)
            0: set_bands(Band1LowReset, Band1HighReset, Band2LowReset, Band2HighReset);
            1: set_bands('0, '0, '0, '0);
            2: set_bands('1, '1, '1, '1);
            3: set_bands('0, '1, '0, '1);
            4: set_bands('1, '0, PeakW'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000)),
                         PeakW'($urandom_range(32'h3FFF_FFFF)));
            default: set_bands(PeakW'($urandom), PeakW'($urandom),
                               PeakW'($urandom), PeakW'($urandom));
         endcase
         phase_end = samples_sent + RandomItems / Phases;
         while (samples_sent < phase_end) begin
            if ($urandom_range(0, 9) < 8) begin
               gaps_on = ($urandom_range(0, 3) != 0);
               send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(7, 24)
                                                       : $urandom_range(1, 6));
            end else begin
               gaps_on = 1'b1;
               send_noise($urandom_range(5, 40));
            end
         end
      end

      drain();
      if (failures == 0 && pending == 0) begin
         $display("four_level_ask_demodulator: match");
      end else begin
         $display("four_level_ask_demodulator: mismatch");
      end
      $finish;
   end

endmodule
